// ===== hw/rtl/hpt_pkg.sv =====
// Shared types, constants and the noise table for the holographic pixel tint block.
// Used by hpt_scan, hpt_tint and holographic_pixel_tint; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    // Configuration register port.
    localparam int CFG_BITS   = 13;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LINE_WIDTH     = 1'b0,
        CFG_ROWS_PER_FRAME = 1'b1
    } cfg_index_t;

    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET     = 13'd640;
    localparam logic [CFG_BITS-1:0] ROWS_PER_FRAME_RESET = 13'd479;

    localparam int COUNT_BITS_DEFAULT = 12;

    // Scan phase and band split.
    localparam int PHASE_BITS = 7;
    localparam logic [PHASE_BITS-1:0] BAND_SPLIT = 7'h58;
    localparam logic [PHASE_BITS-1:0] PHASE_STEP = 7'd37;

    // Pixel fields.
    localparam int CHAN_BITS  = 8;
    localparam int PIXEL_BITS = 24;
    localparam int NOISE_IDX_BITS = 8;
    localparam int NOISE_BITS = 9;
    localparam int NOISE_ENTRIES = 256;

    // Tint arithmetic.
    localparam int SUM_BITS = 12;
    localparam logic [SUM_BITS-1:0] HALF_BIAS    = 12'd100;
    localparam logic [SUM_BITS-1:0] UPPER_FLOOR  = 12'd20;
    localparam logic [SUM_BITS-1:0] LOWER_FLOOR  = 12'd0;
    localparam logic [SUM_BITS-1:0] LOWER_OFFSET = 12'd10;
    localparam logic [SUM_BITS-1:0] BLUE_OFFSET  = 12'd40;
    localparam logic [SUM_BITS-1:0] CHANNEL_MAX  = 12'd255;

    localparam int NOISE_DIVISOR = 40000;
    localparam int NOISE_SCALE   = 256;

    typedef logic [CHAN_BITS-1:0]  chan_t;
    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [NOISE_BITS-1:0] noise_t;
    typedef noise_t [NOISE_ENTRIES-1:0] noise_table_t;

    // Configuration write group.
    typedef struct packed {
        logic                we;
        cfg_index_t          index;
        logic [CFG_BITS-1:0] data;
    } cfg_write_t;

    // Per-pixel scan information taken when the pixel is accepted.
    typedef struct packed {
        logic band_upper;
        logic frame_end;
    } scan_info_t;

    // Entry i is floor(floor(i^3 / 40000) * i / 256); the largest entry is 412.
    function automatic noise_table_t build_noise_table();
        noise_table_t tbl;
        int unsigned  cube;
        int unsigned  quot;
        tbl = '0;
        for (int i = 0; i < NOISE_ENTRIES; i++) begin
            cube   = i * i * i;
            quot   = cube / NOISE_DIVISOR;
            tbl[i] = NOISE_BITS'((quot * i) / NOISE_SCALE);
        end
        return tbl;
    endfunction

    localparam noise_table_t NOISE_TABLE = build_noise_table();

endpackage

`default_nettype wire

// ===== hw/rtl/hpt_scan.sv =====
// Raster scan tracking: configuration registers, column and row counters, scan phase.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_scan #(
    parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire hpt_pkg::cfg_write_t cfg,
    input  wire logic               step,
    output hpt_pkg::scan_info_t     info
);
    import hpt_pkg::*;

    localparam int LIM_BITS = (COUNT_BITS + 1 > CFG_BITS) ? COUNT_BITS + 1 : CFG_BITS;
    localparam logic [LIM_BITS-1:0] COUNT_TOP = LIM_BITS'(1) << COUNT_BITS;

    logic [CFG_BITS-1:0]   line_width_reg, line_width_next;
    logic [CFG_BITS-1:0]   rows_per_frame_reg, rows_per_frame_next;
    logic [COUNT_BITS-1:0] column_count_reg, column_count_next;
    logic [COUNT_BITS-1:0] row_count_reg, row_count_next;
    logic [PHASE_BITS-1:0] scan_phase_reg, scan_phase_next;

    logic [LIM_BITS-1:0]   width_ext, rows_ext;
    logic [LIM_BITS-1:0]   col_last_wide, row_last_wide;
    logic [COUNT_BITS-1:0] col_last, row_last;
    logic                  col_at_end, row_at_end;
    logic [PHASE_BITS-1:0] line_phase;

    // Last valid index: zero acts as one, anything above the counter range saturates.
    always_comb begin
        width_ext = LIM_BITS'(line_width_reg);
        rows_ext  = LIM_BITS'(rows_per_frame_reg);
        if (width_ext == '0) begin
            col_last_wide = '0;
        end else if (width_ext > COUNT_TOP) begin
            col_last_wide = COUNT_TOP - LIM_BITS'(1);
        end else begin
            col_last_wide = width_ext - LIM_BITS'(1);
        end
        if (rows_ext == '0) begin
            row_last_wide = '0;
        end else if (rows_ext > COUNT_TOP) begin
            row_last_wide = COUNT_TOP - LIM_BITS'(1);
        end else begin
            row_last_wide = rows_ext - LIM_BITS'(1);
        end
        col_last   = col_last_wide[COUNT_BITS-1:0];
        row_last   = row_last_wide[COUNT_BITS-1:0];
        col_at_end = (column_count_reg >= col_last);
        row_at_end = (row_count_reg >= row_last);
    end

    always_comb begin
        line_phase      = PHASE_BITS'(row_count_reg) + scan_phase_reg;
        info.band_upper = (line_phase < BAND_SPLIT);
        info.frame_end  = col_at_end && row_at_end;
    end

    always_comb begin
        line_width_next     = line_width_reg;
        rows_per_frame_next = rows_per_frame_reg;
        if (cfg.we) begin
            unique case (cfg.index)
                CFG_LINE_WIDTH:     line_width_next     = cfg.data;
                CFG_ROWS_PER_FRAME: rows_per_frame_next = cfg.data;
                default:            line_width_next     = line_width_reg;
            endcase
        end
    end

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        scan_phase_next   = scan_phase_reg;
        if (step) begin
            if (col_at_end) begin
                column_count_next = '0;
                if (row_at_end) begin
                    row_count_next  = '0;
                    scan_phase_next = scan_phase_reg - PHASE_STEP;
                end else begin
                    row_count_next = row_count_reg + COUNT_BITS'(1);
                end
            end else begin
                column_count_next = column_count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg     <= LINE_WIDTH_RESET;
            rows_per_frame_reg <= ROWS_PER_FRAME_RESET;
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            scan_phase_reg     <= '0;
        end else begin
            line_width_reg     <= line_width_next;
            rows_per_frame_reg <= rows_per_frame_next;
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            scan_phase_reg     <= scan_phase_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/hpt_tint.sv =====
// Combinational tint datapath: noise lookup, luma sum, band formulas and clamps.
// Depends on hpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hpt_tint (
    input  wire hpt_pkg::pixel_t             source_pixel,
    input  wire hpt_pkg::pixel_t             background_pixel,
    input  wire logic                        moving,
    input  wire logic [hpt_pkg::NOISE_IDX_BITS-1:0] noise_index,
    input  wire logic                        band_upper,
    output hpt_pkg::pixel_t                  out_pixel
);
    import hpt_pkg::*;

    // Subtract the bias with a floor: values below floor + bias give the floor.
    function automatic logic [SUM_BITS-1:0] floor_sub(logic [SUM_BITS-1:0] half,
                                                      logic [SUM_BITS-1:0] lo);
        logic [SUM_BITS-1:0] res;
        if (half < lo + HALF_BIAS) begin
            res = lo;
        end else begin
            res = half - HALF_BIAS;
        end
        return res;
    endfunction

    function automatic chan_t saturate(logic [SUM_BITS-1:0] v);
        chan_t res;
        if (v > CHANNEL_MAX) begin
            res = CHAN_BITS'(CHANNEL_MAX);
        end else begin
            res = v[CHAN_BITS-1:0];
        end
        return res;
    endfunction

    chan_t src_r, src_g, src_b, bg_r, bg_g, bg_b;
    noise_t noise;
    logic [SUM_BITS-1:0] luma, red_half, green_half, blue_quarter;
    logic [SUM_BITS-1:0] red_sum, green_sum, blue_sum;

    always_comb begin
        src_r = source_pixel[23:16];
        src_g = source_pixel[15:8];
        src_b = source_pixel[7:0];
        bg_r  = background_pixel[23:16];
        bg_g  = background_pixel[15:8];
        bg_b  = background_pixel[7:0];
        noise = NOISE_TABLE[noise_index];

        if (band_upper) begin
            luma     = SUM_BITS'(src_r) + (SUM_BITS'(src_g) << 1) + SUM_BITS'(src_b)
                     + SUM_BITS'(noise);
            red_half = (SUM_BITS'(src_r[7:1]) + luma) >> 1;
        end else begin
            luma     = SUM_BITS'(src_r) + (SUM_BITS'(src_g) << 2) + SUM_BITS'(src_b)
                     + SUM_BITS'(noise);
            red_half = (SUM_BITS'(src_r) + luma) >> 1;
        end
        green_half   = (SUM_BITS'(src_g) + luma) >> 1;
        blue_quarter = (SUM_BITS'(src_b) + luma) >> 2;

        if (band_upper) begin
            red_sum   = floor_sub(red_half, UPPER_FLOOR) + SUM_BITS'(bg_r[7:1]);
            green_sum = floor_sub(green_half, UPPER_FLOOR) + SUM_BITS'(bg_g[7:1]);
        end else begin
            red_sum   = floor_sub(red_half, LOWER_FLOOR) + SUM_BITS'(bg_r[7:1])
                      + LOWER_OFFSET;
            green_sum = floor_sub(green_half, LOWER_FLOOR) + SUM_BITS'(bg_g[7:1])
                      + LOWER_OFFSET;
        end
        blue_sum = blue_quarter + SUM_BITS'(bg_b[7:1]) + BLUE_OFFSET;

        if (moving) begin
            out_pixel = {saturate(red_sum), saturate(green_sum), saturate(blue_sum)};
        end else begin
            out_pixel = background_pixel;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/holographic_pixel_tint.sv =====
// Top level of the holographic pixel tint block: stream ports, pipeline registers.
// Depends on hpt_pkg, hpt_scan and hpt_tint.
`timescale 1ns / 1ps
`default_nettype none

// Holographic pixel tint. Pixels enter in raster order, one transfer per pixel, and
// leave in the same order, one result transfer per pixel. A still pixel (tuser low)
// leaves as its background pixel; a moving pixel gets a blue-green tint built from a
// luma sum of the camera pixel, a noise term from a fixed 256-entry table and half of
// the background. The formula used depends on whether the current row plus the scan
// phase, taken modulo 128, falls below 88, which makes bands that roll up the image
// as the phase drops by 37 at the end of every frame. m_tlast marks the last pixel
// of each frame. The block takes one pixel per clock while m_tready stays high: there
// is an input register and an output register, and a pixel passes through both on
// its way to m_tvalid. While the output waits, the input still takes one pixel into
// an empty input register and then holds off. Throughput is set only by the output
// side's tready. The user must write line_width and rows_per_frame through the cfg
// port only while no pixel is in flight; the block does not enforce this. Zero acts
// as one and values above the counter range saturate at 2^COUNT_BITS.
module holographic_pixel_tint #(
    parameter int COUNT_BITS = hpt_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port.
    input  wire logic                             cfg_we,
    input  wire logic [hpt_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [hpt_pkg::CFG_BITS-1:0]     cfg_data,
    // Input stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: source_pixel [23:0], background_pixel [47:24], noise_index [55:48].
    input  wire logic [55:0]                      s_tdata,
    // s_tuser: moving [0].
    input  wire logic                             s_tuser,
    // Result stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: out_pixel [23:0].
    output logic [23:0]                           m_tdata,
    // m_tlast: frame_end.
    output logic                                  m_tlast
);
    import hpt_pkg::*;

    // Input register stage.
    logic                      s1_valid_reg, s1_valid_next;
    pixel_t                    s1_src_reg, s1_src_next;
    pixel_t                    s1_bg_reg, s1_bg_next;
    logic                      s1_moving_reg, s1_moving_next;
    logic [NOISE_IDX_BITS-1:0] s1_noise_reg, s1_noise_next;
    scan_info_t                s1_info_reg, s1_info_next;

    // Output register stage.
    logic   m_valid_reg, m_valid_next;
    pixel_t m_pixel_reg, m_pixel_next;
    logic   m_last_reg, m_last_next;

    logic       in_xfer;
    logic       s2_ready;
    logic       s1_advance;
    cfg_write_t cfg;
    scan_info_t scan_info;
    pixel_t     tint_pixel;

    // The output register can take a new pixel when it is empty or being drained;
    // the input register can then move forward and in turn take a new pixel.
    assign s2_ready   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && s2_ready;
    assign s_tready   = !s1_valid_reg || s2_ready;
    assign in_xfer    = s_tvalid && s_tready;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index_t'(cfg_index);
    assign cfg.data  = cfg_data;

    // The counters move once per accepted pixel, so the band and frame-end flags
    // are sampled for that pixel at its transfer.
    hpt_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step    (in_xfer),
        .info    (scan_info)
    );

    hpt_tint u_tint (
        .source_pixel     (s1_src_reg),
        .background_pixel (s1_bg_reg),
        .moving           (s1_moving_reg),
        .noise_index      (s1_noise_reg),
        .band_upper       (s1_info_reg.band_upper),
        .out_pixel        (tint_pixel)
    );

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_src_next    = s1_src_reg;
        s1_bg_next     = s1_bg_reg;
        s1_moving_next = s1_moving_reg;
        s1_noise_next  = s1_noise_reg;
        s1_info_next   = s1_info_reg;
        if (in_xfer) begin
            s1_valid_next  = 1'b1;
            s1_src_next    = s_tdata[23:0];
            s1_bg_next     = s_tdata[47:24];
            s1_noise_next  = s_tdata[55:48];
            s1_moving_next = s_tuser;
            s1_info_next   = scan_info;
        end else if (s1_advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_pixel_next = m_pixel_reg;
        m_last_next  = m_last_reg;
        if (s2_ready) begin
            m_valid_next = s1_valid_reg;
            if (s1_valid_reg) begin
                m_pixel_next = tint_pixel;
                m_last_next  = s1_info_reg.frame_end;
            end
        end
    end

    // Payload registers carry no reset; only the valid flags do.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_src_reg    <= s1_src_next;
        s1_bg_reg     <= s1_bg_next;
        s1_moving_reg <= s1_moving_next;
        s1_noise_reg  <= s1_noise_next;
        s1_info_reg   <= s1_info_next;
        m_pixel_reg   <= m_pixel_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_pixel_reg;
    assign m_tlast  = m_last_reg;

    // A pixel held in the input register is never dropped while the output stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s2_ready |=> s1_valid_reg)
        else $error("input register lost a pixel during an output stall");

    // Nothing appears at the output unless the input register held a pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_valid_reg && s2_ready |=> !m_valid_reg)
        else $error("output became valid without a pixel behind it");

    // A still pixel leaves as its background pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && !s1_moving_reg |=> m_tdata == $past(s1_bg_reg))
        else $error("still pixel did not pass the background through");

    // A tinted pixel always carries at least the fixed blue offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && s1_moving_reg |=> m_tdata[7:0] >= 8'd40)
        else $error("tinted pixel lost its blue offset");

endmodule

`default_nettype wire
